### rtl/core/ptt_pkg.sv
package ptt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = 4;
  localparam int SUB_W   = 8;
  localparam int TIME_W  = 32;
  localparam int EW_W    = 8;
  localparam logic [EW_W-1:0] EW_RESET = 8'd10;

  localparam logic [1:0] CMD_CONNECT = 2'd0;
  localparam logic [1:0] CMD_SERVICE = 2'd1;
  localparam logic [1:0] CMD_DROP    = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic svc;
    logic commit;
    logic done;
    logic drop;
  } ptt_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       last_entry;
    logic       out_busy;
  } ptt_stat_t;

  // a lies strictly before b in wrap order
  function automatic logic wrap_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

### rtl/core/ptt_ctrl.sv
module ptt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ptt_pkg::ptt_stat_t stat,
  output ptt_pkg::ptt_ctrl_t ctrl
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_SVC, S_DONE, S_DROP} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctrl        = '0;
    ctrl.load   = (state == S_IDLE) && in_valid;
    ctrl.scan   = (state == S_SCAN);
    ctrl.commit = (state == S_COMMIT) && !stat.out_busy;
    ctrl.svc    = (state == S_SVC) && !stat.out_busy;
    ctrl.done   = (state == S_DONE) && !stat.out_busy;
    ctrl.drop   = (state == S_DROP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (stat.cmd)
              CMD_CONNECT: state <= S_SCAN;
              CMD_SERVICE: state <= S_SVC;
              default:     state <= S_DROP;
            endcase
          end
        end
        S_SCAN:   if (stat.last_entry) state <= S_COMMIT;
        S_COMMIT: if (!stat.out_busy) state <= S_IDLE;
        S_SVC:    if (!stat.out_busy && stat.last_entry) state <= S_DONE;
        S_DONE:   if (!stat.out_busy) state <= S_IDLE;
        S_DROP:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ptt_dp.sv
module ptt_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [71:0]                in_data,
  input  logic                       cfg_we,
  input  logic [ptt_pkg::EW_W-1:0]   cfg_wdata,
  input  ptt_pkg::ptt_ctrl_t         ctrl,
  output ptt_pkg::ptt_stat_t         stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [39:0]                out_data,
  output logic [1:0]                 out_kind,
  output logic                       out_last
);
  import ptt_pkg::*;

  logic              valid [ENTRIES];
  logic              comb  [ENTRIES];
  logic [SUB_W-1:0]  subs  [ENTRIES];
  logic [TIME_W-1:0] per   [ENTRIES];
  logic [TIME_W-1:0] dl    [ENTRIES];
  logic [EW_W-1:0]   early_window;

  logic [1:0]        cmd_r;
  logic [TIME_W-1:0] now_r, per_r;
  logic              comb_r;
  logic [IDX_W-1:0]  idx_r, cnt;

  logic              match_found, free_found, best_valid;
  logic [IDX_W-1:0]  match_idx, free_idx;
  logic [TIME_W-1:0] best_dl;

  logic [IDX_W-1:0]  o_slot;
  logic [TIME_W-1:0] o_dl;
  logic              o_rearm, o_full;

  logic              cur_valid, fire, best_upd, alloc_early, out_busy;
  logic [TIME_W-1:0] cur_dl, new_dl, vis_dl, diff, cur_best, alloc_dl;
  logic [TIME_W:0]   late;

  always_comb begin
    cur_valid   = valid[cnt];
    cur_dl      = dl[cnt];
    diff        = now_r - cur_dl;
    // expired when signed(now - deadline) >= -early_window
    late        = {diff[TIME_W-1], diff} + {{(TIME_W+1-EW_W){1'b0}}, early_window};
    fire        = cur_valid && !late[TIME_W];
    new_dl      = now_r + per[cnt];
    vis_dl      = fire ? new_dl : cur_dl;
    best_upd    = cur_valid &&
                  (!best_valid || wrap_before(ctrl.svc ? vis_dl : cur_dl, best_dl));
    cur_best    = best_valid ? best_dl : '1;
    alloc_dl    = now_r + per_r;
    alloc_early = !best_valid || wrap_before(alloc_dl, best_dl);
    out_busy    = out_valid && !out_ready;
  end

  assign stat.cmd        = ctrl.load ? in_data[1:0] : cmd_r;
  assign stat.last_entry = (cnt == IDX_W'(ENTRIES - 1));
  assign stat.out_busy   = out_busy;

  assign out_data = {2'b00, o_full, o_rearm, o_dl, o_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        comb[i]  <= 1'b0;
        subs[i]  <= '0;
      end
      early_window <= EW_RESET;
      out_valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      if (cfg_we) early_window <= cfg_wdata;

      if (ctrl.load) begin
        cmd_r       <= in_data[1:0];
        now_r       <= in_data[33:2];
        per_r       <= in_data[65:34];
        comb_r      <= in_data[66];
        idx_r       <= in_data[70:67];
        cnt         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        best_valid  <= 1'b0;
      end

      if (ctrl.scan || ctrl.svc) begin
        cnt <= cnt + 1'b1;
        if (best_upd) begin
          best_valid <= 1'b1;
          best_dl    <= ctrl.svc ? vis_dl : cur_dl;
        end
      end

      if (ctrl.scan) begin
        if (!match_found && cur_valid && comb[cnt] && comb_r && per[cnt] == per_r) begin
          match_found <= 1'b1;
          match_idx   <= cnt;
        end
        if (!free_found && !cur_valid) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
      end

      if (ctrl.svc && fire) begin
        dl[cnt]   <= new_dl;
        out_valid <= 1'b1;
        out_kind  <= KIND_FIRE;
        o_slot    <= cnt;
        o_dl      <= new_dl;
        o_rearm   <= 1'b0;
        o_full    <= 1'b0;
        out_last  <= 1'b0;
      end else if (ctrl.done) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_DONE;
        o_slot    <= '0;
        o_dl      <= cur_best;
        o_rearm   <= 1'b1;
        o_full    <= 1'b0;
        out_last  <= 1'b1;
      end else if (ctrl.commit) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_ACK;
        out_last  <= 1'b1;
        if (match_found && subs[match_idx] != '1) begin
          subs[match_idx] <= subs[match_idx] + 1'b1;
          o_slot          <= match_idx;
          o_dl            <= cur_best;
          o_rearm         <= 1'b0;
          o_full          <= 1'b0;
        end else if (match_found || !free_found) begin
          // saturated count or no free entry
          o_slot  <= '0;
          o_dl    <= cur_best;
          o_rearm <= 1'b0;
          o_full  <= 1'b1;
        end else begin
          valid[free_idx] <= 1'b1;
          comb[free_idx]  <= comb_r;
          per[free_idx]   <= per_r;
          dl[free_idx]    <= alloc_dl;
          subs[free_idx]  <= SUB_W'(1);
          o_slot          <= free_idx;
          o_dl            <= alloc_early ? alloc_dl : best_dl;
          o_rearm         <= alloc_early;
          o_full          <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (ctrl.drop && cmd_r == CMD_DROP && valid[idx_r]) begin
        if (subs[idx_r] != '0) subs[idx_r] <= subs[idx_r] - 1'b1;
        if (subs[idx_r] <= SUB_W'(1)) begin
          valid[idx_r] <= 1'b0;
          comb[idx_r]  <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/periodic_timer_table.sv
// connect: a scan of all 16 entries, then a commit that registers the result
// service: fired entries in entry order, then the done result
// results wait while m_tready is low, and the service walk and the connect commit stall until the waiting one is taken
// one request at a time; s_tready is high only between requests
// rst (synchronous, active high) empties the table and sets early_window to 10
module periodic_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // command, now_ms, period_ms, combine, entry_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // entry_slot, next_deadline, rearm, table_full
  output logic [1:0]  m_tuser,  // kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import ptt_pkg::*;

  ptt_ctrl_t ctrl;
  ptt_stat_t stat;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ptt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

### rtl/core/ptt_checker.sv
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import ptt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("request taken while busy");

  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |-> m_tdata[36] && m_tlast)
    else $error("service done without rearm or last");

  a_fire: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FIRE |-> !m_tlast && !m_tdata[37])
    else $error("fire result marked last or full");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ACK && m_tdata[37] |-> m_tdata[3:0] == '0 && !m_tdata[36])
    else $error("refused connect with slot or rearm");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### tb/sv/periodic_timer_table_test.sv
module periodic_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] deadline;
    logic        rearm;
    logic        full;
    logic        last;
  } timer_result_t;

  typedef struct {
    logic [1:0]    cmd;
    logic [31:0]   now;
    logic [31:0]   period;
    logic          comb;
    logic [3:0]    idx;
    logic          typed;
    timer_result_t answer;
  } timer_row_t;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // own copy of the table
  logic        tbl_valid [ENTRIES];
  logic        tbl_comb  [ENTRIES];
  logic [31:0] tbl_period[ENTRIES];
  logic [31:0] tbl_dl    [ENTRIES];
  logic [7:0]  tbl_subs  [ENTRIES];
  logic [7:0]  window_ms;

  timer_result_t pending_q[$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int hold_cycles = 0;
  logic hold_done = 1'b0;

  periodic_timer_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && (best < 0 || earlier(tbl_dl[i], tbl_dl[best]))) best = i;
    return best;
  endfunction

  function automatic logic [31:0] earliest_dl();
    int e;
    e = earliest_slot();
    return (e < 0) ? 32'hFFFF_FFFF : tbl_dl[e];
  endfunction

  function automatic timer_result_t mk(logic [1:0] k, int s, logic [31:0] d,
                                       logic r, logic f, logic l);
    timer_result_t t;
    t.kind = k; t.slot = 4'(s); t.deadline = d; t.rearm = r; t.full = f; t.last = l;
    return t;
  endfunction

  // advances the table by one request and returns the results it causes
  function automatic void timer_predict(input logic [1:0] cmd, input logic [31:0] now,
                                        input logic [31:0] period, input logic comb,
                                        input logic [3:0] idx, ref timer_result_t res[$]);
    int e, slot;
    logic [31:0] dl;
    logic r;
    res.delete();
    case (cmd)
      CMD_CONNECT: begin
        if (comb) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_comb[i] && tbl_period[i] == period) begin
              if (tbl_subs[i] == 8'hFF) begin
                res = {res, mk(KIND_ACK, 0, earliest_dl(), 1'b0, 1'b1, 1'b1)};
              end else begin
                tbl_subs[i]++;
                res = {res, mk(KIND_ACK, i, earliest_dl(), 1'b0, 1'b0, 1'b1)};
              end
              return;
            end
          end
        end
        e = earliest_slot();
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          res = {res, mk(KIND_ACK, 0, earliest_dl(), 1'b0, 1'b1, 1'b1)};
          return;
        end
        dl = now + period;
        r = (e < 0) || earlier(dl, tbl_dl[e]);
        tbl_valid[slot] = 1'b1;
        tbl_comb[slot] = comb;
        tbl_period[slot] = period;
        tbl_dl[slot] = dl;
        tbl_subs[slot] = 8'd1;
        res = {res, mk(KIND_ACK, slot, earliest_dl(), r, 1'b0, 1'b1)};
      end
      CMD_SERVICE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && int'(now - tbl_dl[i]) >= -int'({24'd0, window_ms})) begin
            tbl_dl[i] = now + tbl_period[i];
            res = {res, mk(KIND_FIRE, i, tbl_dl[i], 1'b0, 1'b0, 1'b0)};
          end
        end
        res = {res, mk(KIND_DONE, 0, earliest_dl(), 1'b1, 1'b0, 1'b1)};
      end
      CMD_DROP: begin
        if (tbl_valid[idx]) begin
          if (tbl_subs[idx] > 0) tbl_subs[idx]--;
          if (tbl_subs[idx] == 0) begin
            tbl_valid[idx] = 1'b0;
            tbl_comb[idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called right after a rising edge; leaves s_tvalid high when no gap follows
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] now,
                              input logic [31:0] period, input logic comb,
                              input logic [3:0] idx, input logic typed,
                              input timer_result_t answer);
    timer_result_t res[$];
    int g;
    s_tdata <= {1'b0, idx, comb, period, now, cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    timer_predict(cmd, now, period, comb, idx, res);
    if (typed) pending_q = {pending_q, answer};
    else foreach (res[i]) pending_q = {pending_q, res[i]};
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] cmd, input logic [31:0] now,
                      input logic [31:0] period, input logic comb, input logic [3:0] idx);
    send_request(cmd, now, period, comb, idx, 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_window(input logic [7:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ms = v;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once results are flowing
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 120) begin
      hold_done <= 1'b1;
      hold_cycles <= 500;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) < 74);
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: kind %0d", m_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser); errors++;
        end
        if (m_tdata[3:0] !== want.slot) begin
          $error("entry_slot: expected %0d, got %0d", want.slot, m_tdata[3:0]); errors++;
        end
        if (m_tdata[35:4] !== want.deadline) begin
          $error("next_deadline: expected %h, got %h", want.deadline, m_tdata[35:4]);
          errors++;
        end
        if (m_tdata[36] !== want.rearm) begin
          $error("rearm: expected %0d, got %0d", want.rearm, m_tdata[36]); errors++;
        end
        if (m_tdata[37] !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, m_tdata[37]); errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast); errors++;
        end
      end
    end
  end

  initial begin
    timer_row_t rows[14];
    logic [1:0]  cmd;
    logic [31:0] now_ms, per;
    int r, pick;
    logic [31:0] periods[4] = '{32'd100, 32'd250, 32'd500, 32'd1000};

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_comb[i] = 1'b0; tbl_period[i] = '0;
      tbl_dl[i] = '0; tbl_subs[i] = '0;
    end
    window_ms = EW_RESET;

    rows[0]  = '{CMD_SERVICE, 32'd0, 32'd0, 1'b0, 4'd0, 1'b1,
                 mk(KIND_DONE, 0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1)};
    rows[1]  = '{CMD_CONNECT, 32'd100, 32'd50, 1'b0, 4'd0, 1'b1,
                 mk(KIND_ACK, 0, 32'd150, 1'b1, 1'b0, 1'b1)};
    rows[2]  = '{CMD_CONNECT, 32'd100, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0, '0};
    rows[3]  = '{CMD_CONNECT, 32'd120, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0, '0};
    rows[4]  = '{CMD_CONNECT, 32'd130, 32'd0, 1'b1, 4'd0, 1'b0, '0};
    rows[5]  = '{CMD_DROP, 32'd0, 32'd0, 1'b0, 4'd15, 1'b0, '0};
    rows[6]  = '{CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b0, '0};
    rows[7]  = '{CMD_SERVICE, 32'd140, 32'd0, 1'b0, 4'd0, 1'b0, '0};
    rows[8]  = '{CMD_DROP, 32'd0, 32'd0, 1'b0, 4'd1, 1'b0, '0};
    rows[9]  = '{CMD_DROP, 32'd0, 32'd0, 1'b0, 4'd1, 1'b0, '0};
    rows[10] = '{CMD_SERVICE, 32'h7FFF_FFFF, 32'd0, 1'b0, 4'd0, 1'b0, '0};
    rows[11] = '{CMD_SERVICE, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, 1'b0, '0};
    rows[12] = '{CMD_CONNECT, 32'hFFFF_FFFF, 32'd1, 1'b0, 4'd0, 1'b0, '0};
    rows[13] = '{CMD_CONNECT, 32'd0, 32'h8000_0000, 1'b1, 4'd0, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_request(rows[i].cmd, rows[i].now, rows[i].period, rows[i].comb, rows[i].idx,
                   rows[i].typed, rows[i].answer);
    // fill every free entry, then one more connect finds the table full
    for (int i = 0; i < ENTRIES; i++)
      if (!tbl_valid[i]) send(CMD_CONNECT, 32'd200 + i, 32'd300 + i, 1'b0, 4'd0);
    send(CMD_CONNECT, 32'd400, 32'd77, 1'b0, 4'd0);
    send(CMD_SERVICE, 32'd700, 32'd0, 1'b0, 4'd0);

    // empty the table, then saturate one combinable entry
    set_window(8'd0);
    for (int i = 0; i < ENTRIES; i++)
      while (tbl_valid[i]) send(CMD_DROP, 32'd0, 32'd0, 1'b0, 4'(i));
    for (int i = 0; i < 257; i++) send(CMD_CONNECT, 32'd1000, 32'd777, 1'b1, 4'd0);
    send(CMD_SERVICE, 32'd1777, 32'd0, 1'b0, 4'd0);
    send(CMD_DROP, 32'd0, 32'd0, 1'b0, 4'd0);
    send(CMD_CONNECT, 32'd1800, 32'd777, 1'b1, 4'd0);

    set_window(8'd255);
    now_ms = 32'd2000;
    for (int n = 0; n < 24; n++) begin
      if (n == 8) wait_drained();
      if (n == 16) set_window(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      cmd = (r < 40) ? CMD_CONNECT : (r < 75) ? CMD_SERVICE : (r < 95) ? CMD_DROP : CMD_SPARE;
      if ($urandom_range(0, 19) == 0) now_ms = $urandom();
      else now_ms = now_ms + $urandom_range(0, 300);
      pick = $urandom_range(0, 9);
      per = (pick < 8) ? periods[pick % 4] : $urandom();
      send(cmd, now_ms, per, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end

    wait_drained();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/core/ptt_pkg.sv
rtl/core/ptt_ctrl.sv
rtl/core/ptt_dp.sv
rtl/core/periodic_timer_table.sv
rtl/core/ptt_checker.sv
tb/sv/periodic_timer_table_test.sv
